// ----- hw/rtl/dwvd_pkg.sv -----
package dwvd_pkg;

  localparam int CAPACITY_DEF = 16;

  localparam int KIND_W   = 3;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;
  localparam int RCNT_W   = 5;

  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DUMP_FWD   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DUMP_BWD   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_REMOVE     = 3'd4;
  localparam logic [KIND_W-1:0] KIND_CLEAR      = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  localparam logic [RCNT_W-1:0] RCNT_MAX = 5'd31;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                push_front;
    logic                push_back;
    logic                clear_all;
    logic                single;
    logic [STATUS_W-1:0] single_status;
    logic                walk_start;
    logic                walk_back;
    logic                rd_issue;
    logic                dump_move;
    logic                rmv_move;
    logic                rmv_finish;
  } dwvd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic full;
    logic out_free;
    logic rd_valid;
    logic rd_last;
    logic all_issued;
  } dwvd_sts_t;

endpackage

// ----- hw/rtl/dwvd_ctrl.sv -----
module dwvd_ctrl import dwvd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [KIND_W-1:0] in_kind,
  input  dwvd_sts_t         sts,
  output dwvd_cmd_t         cmd
);

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_DUMP    = 2'd1;
  localparam logic [1:0] S_RMV     = 2'd2;
  localparam logic [1:0] S_RMV_END = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       dir_r, dir_nxt;
  logic       accept;

  assign in_stall = (state_r != S_IDLE) || !sts.out_free;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    dir_nxt   = dir_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_kind)
            KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
              cmd.single = 1'b1;
              if (sts.full) begin
                cmd.single_status = ST_FULL;
              end else begin
                cmd.single_status = ST_OK;
                cmd.push_front    = (in_kind == KIND_PUSH_FRONT);
                cmd.push_back     = (in_kind == KIND_PUSH_BACK);
              end
            end
            KIND_DUMP_FWD, KIND_DUMP_BWD: begin
              if (sts.empty) begin
                cmd.single        = 1'b1;
                cmd.single_status = ST_EMPTY;
              end else begin
                cmd.walk_start = 1'b1;
                dir_nxt        = (in_kind == KIND_DUMP_BWD);
                state_nxt      = S_DUMP;
              end
            end
            KIND_REMOVE: begin
              if (sts.empty) begin
                cmd.single        = 1'b1;
                cmd.single_status = ST_EMPTY;
              end else begin
                cmd.walk_start = 1'b1;
                dir_nxt        = 1'b0;
                state_nxt      = S_RMV;
              end
            end
            KIND_CLEAR: begin
              cmd.single = 1'b1;
              if (sts.empty) begin
                cmd.single_status = ST_EMPTY;
              end else begin
                cmd.single_status = ST_OK;
                cmd.clear_all     = 1'b1;
              end
            end
            default: begin
              // Unused kinds are taken and dropped without a result.
            end
          endcase
        end
      end
      S_DUMP: begin
        cmd.walk_back = dir_r;
        cmd.dump_move = sts.rd_valid && sts.out_free;
        cmd.rd_issue  = !sts.all_issued && (!sts.rd_valid || cmd.dump_move);
        if (cmd.dump_move && sts.rd_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_RMV: begin
        // The compare stage never stalls, so reads stream one per cycle.
        cmd.rmv_move = sts.rd_valid;
        cmd.rd_issue = !sts.all_issued;
        if (cmd.rmv_move && sts.rd_last) begin
          state_nxt = S_RMV_END;
        end
      end
      S_RMV_END: begin
        if (sts.out_free) begin
          cmd.rmv_finish = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      dir_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      dir_r   <= dir_nxt;
    end
  end

endmodule

// ----- hw/rtl/dwvd_dp.sv -----
module dwvd_dp import dwvd_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dwvd_cmd_t                  cmd,
  output dwvd_sts_t                  sts,
  input  logic signed [VAL_W-1:0]    in_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [STATUS_W-1:0]        out_status,
  output logic signed [VAL_W-1:0]    out_entry_value,
  output logic [RCNT_W-1:0]          out_removed_count,
  output logic                       out_last
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = IW + 1;

  logic [IW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] issue_r, issue_nxt;
  logic [CW-1:0] kept_r, kept_nxt;
  logic          rdv_r, rdv_nxt;
  logic          rd_last_r;

  logic signed [VAL_W-1:0] mem [CAPACITY];
  logic signed [VAL_W-1:0] rd_data_r;
  logic signed [VAL_W-1:0] match_r;

  logic                    wr_en;
  logic [IW-1:0]           wr_addr;
  logic signed [VAL_W-1:0] wr_data;
  logic [CW-1:0]           rd_off;
  logic [IW-1:0]           rd_addr;
  logic [CW-1:0]           gone;

  logic                       out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]        out_status_r;
  logic signed [VAL_W-1:0]    out_entry_r;
  logic [RCNT_W-1:0]          out_rcnt_r;
  logic                       out_last_r;

  // Position of an offset from the head, wrapping round the ring.
  function automatic logic [IW-1:0] ring_pos(input logic [IW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [SW-1:0] sum;
    begin
      sum = {1'b0, base} + SW'(off);
      if (sum >= SW'(CAPACITY)) begin
        sum = sum - SW'(CAPACITY);
      end
      return sum[IW-1:0];
    end
  endfunction

  assign rd_off  = cmd.walk_back ? (count_r - issue_r - CW'(1)) : issue_r;
  assign rd_addr = ring_pos(head_r, rd_off);
  assign gone    = count_r - kept_r;

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    issue_nxt = issue_r;
    kept_nxt  = kept_r;
    wr_en     = 1'b0;
    wr_addr   = ring_pos(head_r, count_r);
    wr_data   = in_value;

    priority if (cmd.push_front) begin
      head_nxt  = (head_r == '0) ? IW'(CAPACITY - 1) : head_r - IW'(1);
      wr_en     = 1'b1;
      wr_addr   = head_nxt;
      count_nxt = count_r + CW'(1);
    end else if (cmd.push_back) begin
      wr_en     = 1'b1;
      count_nxt = count_r + CW'(1);
    end else if (cmd.clear_all) begin
      head_nxt  = '0;
      count_nxt = '0;
    end else if (cmd.rmv_finish) begin
      count_nxt = kept_r;
    end else if (cmd.rmv_move && (rd_data_r != match_r)) begin
      // Survivors are packed down behind the read pointer in order.
      wr_en    = 1'b1;
      wr_addr  = ring_pos(head_r, kept_r);
      wr_data  = rd_data_r;
      kept_nxt = kept_r + CW'(1);
    end else begin
      wr_en = 1'b0;
    end

    if (cmd.walk_start) begin
      issue_nxt = '0;
      kept_nxt  = '0;
    end else if (cmd.rd_issue) begin
      issue_nxt = issue_r + CW'(1);
    end

    if (cmd.rd_issue) begin
      rdv_nxt = 1'b1;
    end else if (cmd.dump_move || cmd.rmv_move) begin
      rdv_nxt = 1'b0;
    end else begin
      rdv_nxt = rdv_r;
    end

    if (cmd.single || cmd.dump_move || cmd.rmv_finish) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_issue) begin
      rd_data_r <= mem[rd_addr];
      rd_last_r <= (issue_r + CW'(1) == count_r);
    end
    if (cmd.walk_start) begin
      match_r <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.single) begin
      out_status_r <= cmd.single_status;
      out_entry_r  <= '0;
      out_rcnt_r   <= '0;
      out_last_r   <= 1'b1;
    end else if (cmd.dump_move) begin
      out_status_r <= ST_OK;
      out_entry_r  <= rd_data_r;
      out_rcnt_r   <= '0;
      out_last_r   <= rd_last_r;
    end else if (cmd.rmv_finish) begin
      out_status_r <= (gone == '0) ? ST_NOT_FOUND : ST_OK;
      out_entry_r  <= '0;
      out_rcnt_r   <= (32'(gone) > 32'(RCNT_MAX)) ? RCNT_MAX : RCNT_W'(gone);
      out_last_r   <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      issue_r     <= '0;
      kept_r      <= '0;
      rdv_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      issue_r     <= issue_nxt;
      kept_r      <= kept_nxt;
      rdv_r       <= rdv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign sts.empty      = (count_r == '0);
  assign sts.full       = (count_r == CW'(CAPACITY));
  assign sts.out_free   = !out_valid_r || !out_stall;
  assign sts.rd_valid   = rdv_r;
  assign sts.rd_last    = rd_last_r;
  assign sts.all_issued = (issue_r == count_r);

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_entry_value   = out_entry_r;
  assign out_removed_count = out_rcnt_r;
  assign out_last          = out_last_r;

endmodule

// ----- hw/rtl/deque_with_value_delete.sv -----
// Push, clear and any item on an empty store: the result word is registered on acceptance.
// Dump: one word per cycle unless out_stall holds, from the ring memory's single read port.
// Remove: one entry read and compared per cycle while survivors are packed.
// A new item waits until the previous item's last word has loaded and out_stall is low.
// Reset (rst_n low, synchronous) empties the store and zeroes the head; the entry
// memory itself is not cleared and is never read before it is written.
module deque_with_value_delete import dwvd_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [KIND_W-1:0]       in_kind,
  input  logic signed [VAL_W-1:0] in_value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [STATUS_W-1:0]     out_status,
  output logic signed [VAL_W-1:0] out_entry_value,
  output logic [RCNT_W-1:0]       out_removed_count,
  output logic                    out_last
);

  dwvd_cmd_t cmd;
  dwvd_sts_t sts;

  dwvd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_kind  (in_kind),
    .sts      (sts),
    .cmd      (cmd)
  );

  dwvd_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_entry_value   (out_entry_value),
    .out_removed_count (out_removed_count),
    .out_last          (out_last)
  );

  // A push is only ever carried out when there is room.
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push_front || cmd.push_back) |-> !sts.full)
    else $error("push carried out on a full store");

  // No read is issued beyond the live entries.
  a_read_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_issue |-> !sts.all_issued)
    else $error("read issued past the last entry");

  // Any word loaded into the output register finds it free.
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.single || cmd.dump_move || cmd.rmv_finish) |-> sts.out_free)
    else $error("output word overwritten while held");

  // A dump or remove word moves only from a filled read stage.
  a_move_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.dump_move || cmd.rmv_move) |-> sts.rd_valid)
    else $error("read stage consumed while empty");

endmodule
